// ----- rtl/lpr_pkg.sv -----
// Package for the length-prefixed packet ring: sizes, codes and the
// command/result records shared by the front end, back end and output buffer.
// No dependencies.
`default_nettype none

package lpr_pkg;

  localparam int DEPTH      = 64;                 // words in the ring, 4..64
  localparam int PTR_W      = $clog2(DEPTH);
  localparam int LEN_W      = 16;
  localparam int WORD_W     = 64;
  localparam int STAT_W     = 3;
  localparam int FUNC_W     = 2;
  localparam int WCNT_W     = LEN_W - 3;          // byte length counted in words
  localparam int CQ_DEPTH   = 2;                  // command queue, power of two
  localparam int CQ_PTR_W   = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_W   = $clog2(CQ_DEPTH + 1);
  localparam int OBUF_DEPTH = 4;                  // result buffer, power of two
  localparam int OBUF_PTR_W = $clog2(OBUF_DEPTH);
  localparam int OBUF_CNT_W = $clog2(OBUF_DEPTH + 1);

  typedef enum logic [FUNC_W-1:0] {
    FN_START = 2'd0,
    FN_DATA  = 2'd1,
    FN_POP   = 2'd2,
    FN_NOP   = 2'd3
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 3'd0,
    ST_ZERO       = 3'd1,
    ST_MISALIGNED = 3'd2,
    ST_TOO_BIG    = 3'd3,
    ST_NO_SPACE   = 3'd4,
    ST_EMPTY      = 3'd5,
    ST_SMALL      = 3'd6,
    ST_WORD       = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_POP   = 2'd2
  } cmd_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE   = 2'd0,
    BK_LEN    = 2'd1,
    BK_STREAM = 2'd2
  } back_state_t;

  // Classified request handed from the front end to the back end
  typedef struct packed {
    cmd_kind_t          kind;
    status_t            pre_status;  // start checks that need no ring state
    logic [PTR_W-1:0]   words;       // start word count, valid when pre_status is OK
    logic [LEN_W-1:0]   len;
    logic [WORD_W-1:0]  data;
  } cmd_t;

  typedef struct packed {
    status_t            status;
    logic [WORD_W-1:0]  word;
    logic [LEN_W-1:0]   bytes;
    logic               last;
  } result_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/lpr_if.sv -----
// Request and result channel interfaces of the packet ring.
// Depends on lpr_pkg for field widths.
`default_nettype none

interface lpr_in_if;
  import lpr_pkg::*;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [LEN_W-1:0]  length_bytes;
  logic [WORD_W-1:0] data_word;
  modport source (output valid, func, length_bytes, data_word, input ready);
  modport sink   (input valid, func, length_bytes, data_word, output ready);
endinterface

interface lpr_out_if;
  import lpr_pkg::*;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [WORD_W-1:0] out_word;
  logic [LEN_W-1:0]  packet_bytes;
  logic              last_word;
  modport source (output valid, status, out_word, packet_bytes, last_word, input ready);
  modport sink   (input valid, status, out_word, packet_bytes, last_word, output ready);
endinterface

`default_nettype wire

// ----- rtl/lpr_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module lpr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- rtl/lpr_front.sv -----
// Front end: accepts requests, runs the start checks that need no ring state,
// and queues classified commands for the back end. Depends on lpr_pkg, lpr_if.
`default_nettype none

module lpr_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  lpr_in_if.sink             in_chan,
  output logic               cmd_valid,
  output lpr_pkg::cmd_t      cmd,
  input  wire logic          cmd_pop
);
  import lpr_pkg::*;

  cmd_t                cq_r [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CQ_CNT_W-1:0] count_r, count_nxt;
  logic                accept;
  logic                push;
  cmd_t                cls;
  logic [WCNT_W-1:0]   wcnt;

  assign in_chan.ready = (count_r != CQ_CNT_W'(CQ_DEPTH));
  assign accept        = in_chan.valid && in_chan.ready;
  assign wcnt          = in_chan.length_bytes[LEN_W-1:3];

  // Classify
  always_comb begin
    cls            = '0;
    cls.len        = in_chan.length_bytes;
    cls.data       = in_chan.data_word;
    cls.words      = wcnt[PTR_W-1:0];
    cls.pre_status = ST_OK;
    push           = 1'b0;
    unique case (func_t'(in_chan.func))
      FN_START: begin
        cls.kind = CMD_START;
        push     = accept;
        if (in_chan.length_bytes == '0) begin
          cls.pre_status = ST_ZERO;
        end else if (in_chan.length_bytes[2:0] != 3'd0) begin
          cls.pre_status = ST_MISALIGNED;
        end else if (wcnt >= WCNT_W'(DEPTH)) begin
          cls.pre_status = ST_TOO_BIG;
        end
      end
      FN_DATA: begin
        cls.kind = CMD_DATA;
        push     = accept;
      end
      FN_POP: begin
        cls.kind = CMD_POP;
        push     = accept;
      end
      default: begin
        cls.kind = CMD_DATA;   // drop no-op requests
        push     = 1'b0;
      end
    endcase
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + CQ_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = cmd_pop ? rd_ptr_r + CQ_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !cmd_pop) begin
      count_nxt = count_r + CQ_CNT_W'(1);
    end else if (!push && cmd_pop) begin
      count_nxt = count_r - CQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      cq_r[wr_ptr_r] <= cls;
    end
  end

  assign cmd_valid = (count_r != '0);
  assign cmd       = cq_r[rd_ptr_r];

endmodule

`default_nettype wire

// ----- rtl/lpr_obuf.sv -----
// Result buffer: a short register queue in front of the result channel.
// The back end never pushes into it when full. Depends on lpr_pkg, lpr_if.
`default_nettype none

module lpr_obuf (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       res_push,
  input  wire lpr_pkg::result_t           res,
  output logic [lpr_pkg::OBUF_CNT_W-1:0]  count,
  lpr_out_if.source                       out_chan
);
  import lpr_pkg::*;

  result_t               buf_r [OBUF_DEPTH];
  logic [OBUF_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [OBUF_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OBUF_CNT_W-1:0] count_r, count_nxt;
  logic                  pop;
  result_t               head;

  assign head                  = buf_r[rd_ptr_r];
  assign out_chan.valid        = (count_r != '0);
  assign out_chan.status       = head.status;
  assign out_chan.out_word     = head.word;
  assign out_chan.packet_bytes = head.bytes;
  assign out_chan.last_word    = head.last;
  assign pop                   = out_chan.valid && out_chan.ready;
  assign count                 = count_r;

  always_comb begin
    wr_ptr_nxt = res_push ? wr_ptr_r + OBUF_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + OBUF_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (res_push && !pop) begin
      count_nxt = count_r + OBUF_CNT_W'(1);
    end else if (!res_push && pop) begin
      count_nxt = count_r - OBUF_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      buf_r[wr_ptr_r] <= res;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lpr_back.sv -----
// Back end: keeps the ring pointers, writes packets into the word store and
// streams popped packets out through the store's read port.
// Depends on lpr_pkg.
`default_nettype none

module lpr_back (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cmd_valid,
  input  wire lpr_pkg::cmd_t                    cmd,
  output logic                                  cmd_pop,
  output logic                                  ram_we,
  output logic      [lpr_pkg::PTR_W-1:0]        ram_waddr,
  output logic      [lpr_pkg::WORD_W-1:0]       ram_wdata,
  output logic                                  ram_re,
  output logic      [lpr_pkg::PTR_W-1:0]        ram_raddr,
  input  wire logic [lpr_pkg::WORD_W-1:0]       ram_rdata,
  input  wire logic [lpr_pkg::OBUF_CNT_W-1:0]   obuf_count,
  output logic                                  res_push,
  output lpr_pkg::result_t                      res
);
  import lpr_pkg::*;

  back_state_t       state_r, state_nxt;
  logic [PTR_W-1:0]  rp_r, rp_nxt;
  logic [PTR_W-1:0]  cwp_r, cwp_nxt;
  logic [PTR_W-1:0]  fp_r, fp_nxt;
  logic [PTR_W-1:0]  rem_r, rem_nxt;
  logic              filling_r, filling_nxt;
  logic [LEN_W-1:0]  cap_r, cap_nxt;
  logic [LEN_W-1:0]  plen_r, plen_nxt;
  logic [PTR_W-1:0]  cnt_r, cnt_nxt;
  logic [PTR_W-1:0]  sp_r, sp_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  logic              rd_last_r, rd_last_nxt;

  logic [PTR_W:0]      used;
  logic [PTR_W:0]      free_words;
  logic [OBUF_CNT_W:0] occ;
  logic                credit_ok;
  logic [LEN_W-1:0]    stored_len;
  logic [WCNT_W-1:0]   stored_wcnt;
  logic [PTR_W-1:0]    stored_words;

  always_comb begin
    if (cwp_r >= rp_r) begin
      used = {1'b0, cwp_r} - {1'b0, rp_r};
    end else begin
      used = {1'b0, cwp_r} + (PTR_W+1)'(DEPTH) - {1'b0, rp_r};
    end
    free_words = (PTR_W+1)'(DEPTH - 1) - used;
  end

  // A read in flight lands in the buffer next cycle, so count it as taken
  assign occ       = {1'b0, obuf_count} + (OBUF_CNT_W+1)'(rd_pend_r);
  assign credit_ok = occ < (OBUF_CNT_W+1)'(OBUF_DEPTH);

  assign stored_len   = ram_rdata[LEN_W-1:0];
  assign stored_wcnt  = stored_len[LEN_W-1:3];
  assign stored_words = (stored_wcnt > WCNT_W'(DEPTH - 2)) ? PTR_W'(DEPTH - 2)
                                                            : stored_wcnt[PTR_W-1:0];

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (cmd_valid && !rd_pend_r && credit_ok && cmd.kind == CMD_POP &&
            rp_r != cwp_r) begin
          state_nxt = BK_LEN;
        end
      end
      BK_LEN: begin
        if (credit_ok) begin
          if (cap_r < stored_len || stored_words == '0) begin
            state_nxt = BK_IDLE;
          end else begin
            state_nxt = BK_STREAM;
          end
        end
      end
      BK_STREAM: begin
        if (credit_ok && cnt_r == PTR_W'(1)) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    cmd_pop     = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = cwp_r;
    ram_wdata   = cmd.data;
    ram_re      = 1'b0;
    ram_raddr   = rp_r;
    res_push    = 1'b0;
    res         = '0;
    res.last    = 1'b1;
    rp_nxt      = rp_r;
    cwp_nxt     = cwp_r;
    fp_nxt      = fp_r;
    rem_nxt     = rem_r;
    filling_nxt = filling_r;
    cap_nxt     = cap_r;
    plen_nxt    = plen_r;
    cnt_nxt     = cnt_r;
    sp_nxt      = sp_r;
    rd_pend_nxt = 1'b0;
    rd_last_nxt = rd_last_r;

    // Word read last cycle
    if (rd_pend_r) begin
      res_push     = 1'b1;
      res.status   = ST_WORD;
      res.word     = ram_rdata;
      res.bytes    = plen_r;
      res.last     = rd_last_r;
    end

    unique case (state_r)
      BK_IDLE: begin
        if (cmd_valid && !rd_pend_r) begin
          unique case (cmd.kind)
            CMD_START: begin
              if (credit_ok) begin
                cmd_pop     = 1'b1;
                res_push    = 1'b1;
                // drop any open fill
                filling_nxt = 1'b0;
                rem_nxt     = '0;
                fp_nxt      = cwp_r;
                if (cmd.pre_status != ST_OK) begin
                  res.status = cmd.pre_status;
                end else if ({1'b0, cmd.words} >= free_words) begin
                  res.status = ST_NO_SPACE;
                end else begin
                  res.status  = ST_OK;
                  ram_we      = 1'b1;
                  ram_waddr   = cwp_r;
                  ram_wdata   = {{(WORD_W-LEN_W){1'b0}}, cmd.len};
                  fp_nxt      = ptr_inc(cwp_r);
                  rem_nxt     = cmd.words;
                  filling_nxt = 1'b1;
                end
              end
            end
            CMD_DATA: begin
              cmd_pop = 1'b1;
              if (filling_r) begin
                ram_we    = 1'b1;
                ram_waddr = fp_r;
                ram_wdata = cmd.data;
                fp_nxt    = ptr_inc(fp_r);
                rem_nxt   = rem_r - PTR_W'(1);
                if (rem_r == PTR_W'(1)) begin
                  cwp_nxt     = ptr_inc(fp_r);
                  filling_nxt = 1'b0;
                end
              end
            end
            CMD_POP: begin
              if (credit_ok) begin
                cmd_pop = 1'b1;
                if (rp_r == cwp_r) begin
                  res_push   = 1'b1;
                  res.status = ST_EMPTY;
                end else begin
                  ram_re    = 1'b1;
                  ram_raddr = rp_r;
                  cap_nxt   = cmd.len;
                end
              end
            end
            default: cmd_pop = 1'b0;
          endcase
        end
      end
      BK_LEN: begin
        // length word sits on the read port
        if (credit_ok) begin
          if (cap_r < stored_len) begin
            res_push   = 1'b1;
            res.status = ST_SMALL;
            res.bytes  = stored_len;
          end else if (stored_words == '0) begin
            res_push   = 1'b1;
            res.status = ST_EMPTY;
            rp_nxt     = ptr_inc(rp_r);
          end else begin
            plen_nxt = stored_len;
            cnt_nxt  = stored_words;
            sp_nxt   = ptr_inc(rp_r);
          end
        end
      end
      BK_STREAM: begin
        if (credit_ok) begin
          ram_re      = 1'b1;
          ram_raddr   = sp_r;
          sp_nxt      = ptr_inc(sp_r);
          cnt_nxt     = cnt_r - PTR_W'(1);
          rd_pend_nxt = 1'b1;
          rd_last_nxt = (cnt_r == PTR_W'(1));
          if (cnt_r == PTR_W'(1)) begin
            rp_nxt = ptr_inc(sp_r);
          end
        end
      end
      default: cmd_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      rp_r      <= '0;
      cwp_r     <= '0;
      fp_r      <= '0;
      rem_r     <= '0;
      filling_r <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rp_r      <= rp_nxt;
      cwp_r     <= cwp_nxt;
      fp_r      <= fp_nxt;
      rem_r     <= rem_nxt;
      filling_r <= filling_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cap_r     <= cap_nxt;
    plen_r    <= plen_nxt;
    cnt_r     <= cnt_nxt;
    sp_r      <= sp_nxt;
    rd_last_r <= rd_last_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/length_prefixed_packet_ring.sv -----
// Top level of the length-prefixed packet ring.
// Depends on lpr_pkg, lpr_if, lpr_ram, lpr_front, lpr_obuf, lpr_back.
`default_nettype none

// A ring of DEPTH 64-bit words holding whole packets, each stored as a
// length word followed by its data words. Requests enter through a
// two-entry command queue and are carried out in order by a back-end
// sequencer that owns the ring pointers and the single-port-per-direction
// word store; results leave through a four-entry buffer, so the request side
// keeps flowing while a result waits. A pop reads the length word, judges
// it, then reads the data words in turn, since every word goes through the
// store's one registered read port, and closes the stream; a stalled
// result side holds the stream once the buffer is full. The sequencer
// takes its next command only once the stream has closed.
// No clearing pass follows reset.
module length_prefixed_packet_ring (
  input wire logic   clk,
  input wire logic   rst_n,
  lpr_in_if.sink     in_chan,
  lpr_out_if.source  out_chan
);
  import lpr_pkg::*;

  logic                  cmd_valid;
  cmd_t                  cmd;
  logic                  cmd_pop;
  logic                  ram_we;
  logic [PTR_W-1:0]      ram_waddr;
  logic [WORD_W-1:0]     ram_wdata;
  logic                  ram_re;
  logic [PTR_W-1:0]      ram_raddr;
  logic [WORD_W-1:0]     ram_rdata;
  logic [OBUF_CNT_W-1:0] obuf_count;
  logic                  res_push;
  result_t               res;

  lpr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  lpr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lpr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .obuf_count (obuf_count),
    .res_push   (res_push),
    .res        (res)
  );

  lpr_obuf u_obuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_push (res_push),
    .res      (res),
    .count    (obuf_count),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire
